@@ rtl/nfhl_pkg.sv @@
// Shared types, sizes and codes for the fix history logger.
package nfhl_pkg;

    // Sizing of the history ring and the line buffer.
    localparam int HISTORY_DEPTH = 60;
    localparam int LINE_LENGTH   = 128;

    // Layout of one history entry: latitude characters, then longitude characters.
    localparam int LAT_CHARS   = 9;
    localparam int LON_CHARS   = 10;
    localparam int ENTRY_CHARS = LAT_CHARS + LON_CHARS;
    localparam int LAT_COL     = 18;
    localparam int LON_COL     = 30;
    localparam int STATUS_COL  = 5;

    // Characters that the logic looks for.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_VALID  = 8'h41;

    // Derived widths.
    localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int LINE_AW   = $clog2(LINE_LENGTH);
    localparam int LINE_CW   = $clog2(LINE_LENGTH + 1);
    localparam int FIX_DEPTH = HISTORY_DEPTH * ENTRY_CHARS;
    localparam int FIX_AW    = $clog2(FIX_DEPTH);
    localparam int KW        = $clog2(ENTRY_CHARS + 1);

    // Stream widths and field sizes.
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int OUT_SLOT_W = 6;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // Operation codes as they arrive on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_BYTE = 3'd0,
        OP_TICK = 3'd1,
        OP_NOW  = 3'd2,
        OP_PREV = 3'd3,
        OP_NEXT = 3'd4,
        OP_READ = 3'd5
    } t_op;

    // Classified command kinds handed to the back end.
    typedef enum logic [2:0] {
        CMD_BYTE = 3'd0,
        CMD_TICK = 3'd1,
        CMD_NOW  = 3'd2,
        CMD_PREV = 3'd3,
        CMD_NEXT = 3'd4,
        CMD_READ = 3'd5,
        CMD_NONE = 3'd6
    } t_cmd_kind;

    // One queued command with its pre-decoded flags.
    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             dollar;
        logic             pos_ok;
    } t_cmd;

    // Line column read for character k of a history entry.
    function automatic logic [LINE_AW-1:0] f_copy_col(input logic [KW-1:0] k);
        if (k < KW'(LAT_CHARS)) begin
            return LINE_AW'(LAT_COL) + LINE_AW'(k);
        end
        return LINE_AW'(LON_COL - LAT_CHARS) + LINE_AW'(k);
    endfunction

endpackage

@@ rtl/nfhl_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module nfhl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/nfhl_front.sv @@
// Front end: accepts input beats, classifies them and holds them in a short queue.
module nfhl_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [nfhl_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [nfhl_pkg::OP_W-1:0]        i_s_tuser,
    output nfhl_pkg::t_cmd                   o_cmd,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_pop
);

    nfhl_pkg::t_cmd               r_q [nfhl_pkg::QUEUE_DEPTH];
    logic [nfhl_pkg::QAW-1:0]     r_wr_ptr;
    logic [nfhl_pkg::QAW-1:0]     r_rd_ptr;
    logic [nfhl_pkg::QCW-1:0]     r_count;
    nfhl_pkg::t_cmd               w_cmd;
    logic                         w_push;
    logic                         w_pop;

    // Classify the incoming beat.
    always_comb begin
        w_cmd.data   = i_s_tdata[7:0];
        w_cmd.pos    = i_s_tdata[12:8];
        w_cmd.dollar = (i_s_tdata[7:0] == nfhl_pkg::CHAR_DOLLAR);
        w_cmd.pos_ok = (i_s_tdata[12:8] < nfhl_pkg::POS_W'(nfhl_pkg::ENTRY_CHARS));
        unique case (i_s_tuser)
            nfhl_pkg::OP_BYTE: w_cmd.kind = nfhl_pkg::CMD_BYTE;
            nfhl_pkg::OP_TICK: w_cmd.kind = nfhl_pkg::CMD_TICK;
            nfhl_pkg::OP_NOW:  w_cmd.kind = nfhl_pkg::CMD_NOW;
            nfhl_pkg::OP_PREV: w_cmd.kind = nfhl_pkg::CMD_PREV;
            nfhl_pkg::OP_NEXT: w_cmd.kind = nfhl_pkg::CMD_NEXT;
            nfhl_pkg::OP_READ: w_cmd.kind = nfhl_pkg::CMD_READ;
            default:           w_cmd.kind = nfhl_pkg::CMD_NONE;
        endcase
    end

    assign o_s_tready  = (r_count < nfhl_pkg::QCW'(nfhl_pkg::QUEUE_DEPTH));
    assign w_push      = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/nfhl_back.sv @@
// Back end: executes queued commands against the line buffer and history ring.
module nfhl_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  nfhl_pkg::t_cmd                   i_cmd,
    input  logic                             i_cmd_valid,
    output logic                             o_cmd_pop,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [nfhl_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COPY = 4'b0010,
        ST_READ = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    logic [nfhl_pkg::LINE_CW-1:0]      r_line_pos;
    logic [nfhl_pkg::LINE_CW-1:0]      r_line_fill;
    logic [7:0]                        r_status;
    logic [nfhl_pkg::SLOT_W-1:0]       r_write_slot;
    logic [nfhl_pkg::SLOT_W-1:0]       r_display_slot;
    logic                              r_browse;
    logic [nfhl_pkg::HISTORY_DEPTH-1:0] r_slot_valid;
    logic [nfhl_pkg::KW-1:0]           r_k;
    logic [nfhl_pkg::FIX_AW-1:0]       r_fix_addr;
    logic                              r_line_hit;
    logic [7:0]                        r_char;
    logic                              r_out_valid;
    logic [nfhl_pkg::OUT_DATA_W-1:0]   r_out_data;

    logic [nfhl_pkg::LINE_CW-1:0]      w_byte_pos;
    logic                              w_line_we;
    logic [nfhl_pkg::LINE_AW-1:0]      w_line_raddr;
    logic [7:0]                        w_line_rdata;
    logic                              w_fix_we;
    logic [7:0]                        w_fix_wdata;
    logic [nfhl_pkg::FIX_AW-1:0]       w_fix_raddr;
    logic [7:0]                        w_fix_rdata;
    logic                              w_copy_done;
    logic                              w_read_hit;
    logic                              w_out_load;
    logic                              w_fix_ok;

    localparam logic [nfhl_pkg::SLOT_W-1:0] LastSlot =
        nfhl_pkg::SLOT_W'(nfhl_pkg::HISTORY_DEPTH - 1);

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    // Line position that an incoming byte lands on; a dollar restarts the line.
    assign w_byte_pos = i_cmd.dollar ? '0 : r_line_pos;
    assign w_line_we  = o_cmd_pop && (i_cmd.kind == nfhl_pkg::CMD_BYTE)
                        && (w_byte_pos < nfhl_pkg::LINE_CW'(nfhl_pkg::LINE_LENGTH));

    // Copy sequence: read one line column per cycle, write it in the following cycle.
    assign w_line_raddr = nfhl_pkg::f_copy_col(r_k);
    assign w_fix_we     = (r_state == ST_COPY) && (r_k != '0);
    assign w_fix_wdata  = r_line_hit ? w_line_rdata : 8'h00;
    assign w_copy_done  = (r_state == ST_COPY) && (r_k == nfhl_pkg::KW'(nfhl_pkg::ENTRY_CHARS));
    assign w_fix_ok     = (r_status == nfhl_pkg::CHAR_VALID);

    // Readout address into the shown entry; entries never filled read as zero.
    assign w_fix_raddr = nfhl_pkg::FIX_AW'(r_display_slot)
                         * nfhl_pkg::FIX_AW'(nfhl_pkg::ENTRY_CHARS)
                         + nfhl_pkg::FIX_AW'(i_cmd.pos);
    assign w_read_hit  = i_cmd.pos_ok && r_slot_valid[r_display_slot];

    assign w_out_load = (r_state == ST_EMIT) && (!r_out_valid || i_m_tready);

    nfhl_ram #(
        .WIDTH (8),
        .DEPTH (nfhl_pkg::LINE_LENGTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (w_byte_pos[nfhl_pkg::LINE_AW-1:0]),
        .i_wdata (i_cmd.data),
        .i_raddr (w_line_raddr),
        .o_rdata (w_line_rdata)
    );

    nfhl_ram #(
        .WIDTH (8),
        .DEPTH (nfhl_pkg::FIX_DEPTH)
    ) u_fix_ram (
        .i_clk   (i_clk),
        .i_we    (w_fix_we),
        .i_waddr (r_fix_addr),
        .i_wdata (w_fix_wdata),
        .i_raddr (w_fix_raddr),
        .o_rdata (w_fix_rdata)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = ST_EMIT;
                    if (i_cmd.kind == nfhl_pkg::CMD_TICK && w_fix_ok) begin
                        n_state = ST_COPY;
                    end else if (i_cmd.kind == nfhl_pkg::CMD_READ && w_read_hit) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_COPY: begin
                if (w_copy_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_READ: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state: line tracking, ring pointers, browse flag and slot valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_line_pos     <= '0;
            r_line_fill    <= '0;
            r_status       <= '0;
            r_write_slot   <= '0;
            r_display_slot <= '0;
            r_browse       <= 1'b0;
            r_slot_valid   <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop) begin
                unique case (i_cmd.kind)
                    nfhl_pkg::CMD_BYTE: begin
                        if (w_line_we) begin
                            r_line_pos <= w_byte_pos + 1'b1;
                            if (w_byte_pos >= r_line_fill) begin
                                r_line_fill <= w_byte_pos + 1'b1;
                            end
                            if (w_byte_pos == nfhl_pkg::LINE_CW'(nfhl_pkg::STATUS_COL)) begin
                                r_status <= i_cmd.data;
                            end
                        end
                    end
                    nfhl_pkg::CMD_NOW: begin
                        r_browse <= 1'b0;
                        r_display_slot <= (r_write_slot == '0) ? LastSlot
                                                               : r_write_slot - 1'b1;
                    end
                    nfhl_pkg::CMD_PREV: begin
                        r_browse <= 1'b1;
                        if (r_display_slot != '0) begin
                            r_display_slot <= r_display_slot - 1'b1;
                        end
                    end
                    nfhl_pkg::CMD_NEXT: begin
                        r_browse <= 1'b1;
                        if (r_display_slot < LastSlot) begin
                            r_display_slot <= r_display_slot + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // A finished copy commits the slot and moves the ring on.
            if (w_copy_done) begin
                r_slot_valid[r_write_slot] <= 1'b1;
                if (!r_browse) begin
                    r_display_slot <= r_write_slot;
                end
                r_write_slot <= (r_write_slot == LastSlot) ? '0 : r_write_slot + 1'b1;
            end
        end
    end

    // Copy counters, line hit flag and readout character.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_k        <= '0;
            r_fix_addr <= nfhl_pkg::FIX_AW'(r_write_slot)
                          * nfhl_pkg::FIX_AW'(nfhl_pkg::ENTRY_CHARS);
            r_char     <= 8'h00;
        end else if (r_state == ST_COPY) begin
            r_k <= r_k + 1'b1;
            if (r_k != '0) begin
                r_fix_addr <= r_fix_addr + 1'b1;
            end
        end else if (r_state == ST_READ) begin
            r_char <= w_fix_rdata;
        end
        r_line_hit <= (nfhl_pkg::LINE_CW'(w_line_raddr) < r_line_fill);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {3'b000, r_char,
                           nfhl_pkg::OUT_SLOT_W'(r_write_slot),
                           r_browse,
                           nfhl_pkg::OUT_SLOT_W'(r_display_slot)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ rtl/nmea_fix_history_logger_top.sv @@
// Channel   Dir  Signals                               Contents
// s (in)    in   i_s_tvalid/o_s_tready/tdata/tuser     one command beat per item
// m (out)   out  o_m_tvalid/i_m_tready/o_m_tdata       one status beat per item
//
// A tick with a valid fix copies the entry from the line RAM into the history
// RAM, one character per cycle. A two-beat command queue keeps input flowing
// while the back end works or the output beat waits. Reset is synchronous and
// needs no clearing pass: a fill count covers the line RAM, and per-slot valid
// bits cover the history RAM.
module nmea_fix_history_logger_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [7:0] rx_byte, [12:8] char_position, [15:13] zero
    input  logic [nfhl_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [2:0] operation
    input  logic [nfhl_pkg::OP_W-1:0]        i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [5:0] shown_slot, [6] browsing, [12:7] next_slot, [20:13] char_out, [23:21] zero
    output logic [nfhl_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    nfhl_pkg::t_cmd w_cmd;
    logic           w_cmd_valid;
    logic           w_cmd_pop;

    // Accept and classify.
    nfhl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Execute and report.
    nfhl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
